[rtl/isr_pkg.sv]
// Shared widths and the pipeline word carried between square root stages.
`timescale 1ns / 1ps
package isr_pkg;
  localparam int VAL_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = ROOT_W + 3;

  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [VAL_W-1:0]  data;
  } stage_t;
endpackage

[rtl/isr_stage.sv]
// One digit step of the restoring square root: one result bit per stage.
`timescale 1ns / 1ps
module isr_stage (
  input  logic            clk,
  input  logic            rst,
  input  isr_pkg::stage_t din,
  output isr_pkg::stage_t dout
);
  import isr_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;
  stage_t           dout_next;

  always_comb begin
    rem_sh = {din.rem[REM_W-3:0], din.data[VAL_W-1 -: 2]};
    trial  = {1'b0, din.root, 2'b01};
    take   = (rem_sh >= trial);
    dout_next.valid = din.valid;
    dout_next.rem   = take ? (rem_sh - trial) : rem_sh;
    dout_next.root  = {din.root[ROOT_W-2:0], take};
    dout_next.data  = {din.data[VAL_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= dout_next.valid;
    end
    dout.rem  <= dout_next.rem;
    dout.root <= dout_next.root;
    dout.data <= dout_next.data;
  end
endmodule

[rtl/integer_square_root_64.sv]
// Top level: pipelined 64-bit floor square root.
//
// Usage: drive value and raise start for one cycle per word; busy is always
// low, so a word is taken at every edge where start is high. The block keeps
// no state between words.
// Pipeline: a word taken with start passes through 32 register stages, one
// result bit each, set by the compare and subtract on a 35-bit remainder per
// stage, and its root then appears on root with done high.
// Throughput: one word per cycle.
// Reset: clears every stage valid bit; words in flight are dropped and done
// stays low until new words come through. No clearing pass is needed.
// Receiver: cannot stall; root and done are valid for exactly one cycle.
`timescale 1ns / 1ps
module integer_square_root_64 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [isr_pkg::VAL_W-1:0] value,
  output logic                      done,
  output logic [isr_pkg::ROOT_W-1:0] root
);
  import isr_pkg::*;

  stage_t pipe [0:ROOT_W];

  assign busy = 1'b0;

  always_comb begin
    pipe[0].valid = start;
    pipe[0].rem   = '0;
    pipe[0].root  = '0;
    pipe[0].data  = value;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    isr_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .din  (pipe[i]),
      .dout (pipe[i+1])
    );
  end

  assign done = pipe[ROOT_W].valid;
  assign root = pipe[ROOT_W].root;

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, ROOT_W))
    else $error("done without a word accepted 32 cycles earlier");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done high right after reset");
endmodule

[tb/integer_square_root_64_test.sv]
// Testbench for the pipelined 64-bit floor square root: directed and random words.
`timescale 1ns / 1ps
module integer_square_root_64_test;
  import isr_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [VAL_W-1:0]  value;
  logic              done;
  logic [ROOT_W-1:0] root;

  logic [ROOT_W-1:0] root_queue[$];
  int                fail_count;
  bit                allow_gaps;

  integer_square_root_64 i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .value(value), .done(done), .root(root)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [63:0] quot_nz(logic [63:0] num, logic [63:0] den);
    if (den == 64'd0) begin
      return num;
    end
    return num / den;
  endfunction

  function automatic logic [ROOT_W-1:0] floor_root(logic [VAL_W-1:0] v);
    logic [63:0] m;
    logic [63:0] est;
    logic [63:0] half;
    logic [63:0] blen;
    if (v == 64'd0) begin
      return '0;
    end
    blen = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        blen = 64'(i + 1);
      end
    end
    half = (blen - 1) / 2;
    m = v << (62 - 2 * half);
    est = (64'd1 + (m >> 62)) & 64'hFFFF_FFFF;
    est = ((est << 1) + quot_nz(m >> 59, est)) & 64'hFFFF_FFFF;
    est = ((est << 3) + quot_nz(m >> 53, est)) & 64'hFFFF_FFFF;
    est = ((est << 7) + quot_nz(m >> 41, est)) & 64'hFFFF_FFFF;
    est = ((est << 15) & 64'hFFFF_FFFF) + quot_nz(m >> 17, est);
    est = est >> (31 - half);
    if (est * est - 64'd1 >= v) begin
      est = est - 64'd1;
    end
    return est[ROOT_W-1:0];
  endfunction

  task automatic send_word(logic [VAL_W-1:0] v);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    root_queue.push_back(floor_root(v));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (root_queue.size() == 0) begin
        $error("root: unexpected word, actual %0d", root);
        fail_count++;
      end else begin
        logic [ROOT_W-1:0] want;
        want = root_queue.pop_front();
        if (root !== want) begin
          $error("root: expected %0d, actual %0d", want, root);
          fail_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    logic [VAL_W-1:0] sq;
    send_word(64'd0);
    send_word(64'd1);
    send_word(64'd2);
    send_word(64'd3);
    send_word(64'd4);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'hFFFF_FFFE_0000_0001);
    send_word(64'hFFFF_FFFE_0000_0000);
    send_word(64'h8000_0000_0000_0000);
    send_word(64'h7FFF_FFFF_FFFF_FFFF);
    send_word(64'h5555_5555_5555_5555);
    send_word(64'hAAAA_AAAA_AAAA_AAAA);
    for (int k = 0; k < 6; k++) begin
      sq = 64'd1 << (2 * $urandom_range(1, 31));
      send_word(sq);
      send_word(sq - 1);
    end
  endtask

  task automatic test_random(int count);
    logic [63:0] r;
    logic [63:0] v;
    for (int n = 0; n < count; n++) begin
      r = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
        0: v = r;
        1: v = r >> $urandom_range(0, 63);
        2: begin
          r = r & 64'hFFFF_FFFF;
          v = r * r + $urandom_range(0, 2) - 1;
        end
        default: v = ~(r >> $urandom_range(0, 63));
      endcase
      send_word(v);
    end
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    fail_count = 0;
    allow_gaps = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random(800);
    allow_gaps = 1'b0;
    test_random(150);
    start <= 1'b0;
    wait_cycles = 0;
    while (root_queue.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && root_queue.size() == 0) begin
      $display("integer_square_root_64_test OK");
    end else begin
      $display("integer_square_root_64_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("integer_square_root_64_test NOT OK");
    $finish;
  end
endmodule

[filelist.f]
rtl/isr_pkg.sv
rtl/isr_stage.sv
rtl/integer_square_root_64.sv
tb/integer_square_root_64_test.sv
